@@ src/rdc_pkg.sv @@
`default_nettype none
package rdc_pkg;

   // Fixed field widths
   localparam int RADIX_W = 6;
   localparam int DIGIT_W = 6;

   // Smallest usable radix; 0 and 1 are promoted to it
   localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);

   // Entries in the queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_POP
   } rdc_back_state_type;

endpackage
`default_nettype wire

@@ src/rdc_front.sv @@
`default_nettype none
module rdc_front #(
   parameter int VALUE_BITS = 31
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [VALUE_BITS-1:0]       req_value,
   input  wire logic [rdc_pkg::RADIX_W-1:0] req_radix,
   output logic                             item_valid,
   output logic [VALUE_BITS-1:0]            item_value,
   output logic [rdc_pkg::RADIX_W-1:0]      item_radix,
   input  wire logic                        item_pop
);
   import rdc_pkg::*;

   logic [VALUE_BITS-1:0] value_q_ff [QUEUE_DEPTH];
   logic [RADIX_W-1:0]    radix_q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic                  push;
   logic [RADIX_W-1:0]    radix_norm;

   assign busy       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push       = start && !busy;
   assign item_valid = (count_ff != '0);
   assign item_value = value_q_ff[rd_ptr_ff];
   assign item_radix = radix_q_ff[rd_ptr_ff];

   // radix 0 and 1 run as binary
   assign radix_norm = (req_radix < RADIX_MIN) ? RADIX_MIN : req_radix;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = item_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !item_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push && item_pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         value_q_ff[wr_ptr_ff] <= req_value;
         radix_q_ff[wr_ptr_ff] <= radix_norm;
      end
   end

endmodule
`default_nettype wire

@@ src/rdc_back.sv @@
`default_nettype none
module rdc_back #(
   parameter int VALUE_BITS  = 31,
   parameter int STACK_DEPTH = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        item_valid,
   input  wire logic [VALUE_BITS-1:0]       item_value,
   input  wire logic [rdc_pkg::RADIX_W-1:0] item_radix,
   output logic                             item_pop,
   output logic                             rsp_strobe,
   output logic [rdc_pkg::DIGIT_W-1:0]      rsp_digit,
   output logic                             rsp_last_digit
);
   import rdc_pkg::*;

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int SCNT_W = $clog2(STACK_DEPTH + 1);
   localparam int BIT_W  = $clog2(VALUE_BITS);
   localparam logic [BIT_W-1:0]  LAST_BIT = BIT_W'(VALUE_BITS - 1);
   localparam logic [SCNT_W-1:0] FULL_CNT = SCNT_W'(STACK_DEPTH);

   rdc_back_state_type    state_ff, state_in;
   logic [VALUE_BITS-1:0] quot_ff, quot_in;
   logic [RADIX_W-1:0]    rem_ff, rem_in;
   logic [RADIX_W-1:0]    radix_ff, radix_in;
   logic [BIT_W-1:0]      bit_ff, bit_in;
   logic [SCNT_W-1:0]     scnt_ff, scnt_in;
   logic                  strobe_ff, strobe_in;
   logic                  last_ff, last_in;
   logic [DIGIT_W-1:0]    rd_data_ff;

   logic [DIGIT_W-1:0]    stack_mem [STACK_DEPTH];
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [DIGIT_W-1:0]    wr_data;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;

   // one restoring division step
   logic [RADIX_W:0]      trial;
   logic                  fits;
   logic [RADIX_W-1:0]    rem_step;
   logic [VALUE_BITS-1:0] quot_step;

   assign trial     = {rem_ff, quot_ff[VALUE_BITS-1]};
   assign fits      = (trial >= {1'b0, radix_ff});
   assign rem_step  = fits ? RADIX_W'(trial - {1'b0, radix_ff}) : trial[RADIX_W-1:0];
   assign quot_step = {quot_ff[VALUE_BITS-2:0], fits};

   always_comb begin
      state_in  = state_ff;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      radix_in  = radix_ff;
      bit_in    = bit_ff;
      scnt_in   = scnt_ff;
      strobe_in = 1'b0;
      last_in   = last_ff;
      item_pop  = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = scnt_ff[ADDR_W-1:0];
      wr_data   = rem_step;
      rd_en     = 1'b0;
      rd_addr   = ADDR_W'(scnt_ff - SCNT_W'(1));

      unique case (state_ff)
         BK_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               quot_in  = item_value;
               radix_in = item_radix;
               rem_in   = '0;
               bit_in   = '0;
               if (item_value == '0) begin
                  // zero converts to the single digit 0
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = '0;
                  scnt_in  = SCNT_W'(1);
                  state_in = BK_POP;
               end else begin
                  scnt_in  = '0;
                  state_in = BK_DIV;
               end
            end
         end
         BK_DIV: begin
            quot_in = quot_step;
            rem_in  = rem_step;
            bit_in  = bit_ff + BIT_W'(1);
            if (bit_ff == LAST_BIT) begin
               bit_in = '0;
               rem_in = '0;
               // stack full: more significant digits are dropped
               if (scnt_ff < FULL_CNT) begin
                  wr_en   = 1'b1;
                  scnt_in = scnt_ff + SCNT_W'(1);
               end
               if (quot_step == '0) begin
                  state_in = BK_POP;
               end
            end
         end
         BK_POP: begin
            rd_en     = 1'b1;
            strobe_in = 1'b1;
            last_in   = (scnt_ff == SCNT_W'(1));
            scnt_in   = scnt_ff - SCNT_W'(1);
            if (scnt_ff == SCNT_W'(1)) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         scnt_ff   <= '0;
         quot_ff   <= '0;
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         scnt_ff   <= scnt_in;
         quot_ff   <= quot_in;
         strobe_ff <= strobe_in;
         last_ff   <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      radix_ff <= radix_in;
      bit_ff   <= bit_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_digit      = rd_data_ff;
   assign rsp_last_digit = last_ff;

endmodule
`default_nettype wire

@@ src/radix_digit_converter.sv @@
`default_nettype none
// Integer to radix digits.
// Input: raise start with req_value and req_radix; the item is taken at a
// clock edge where start is high and busy is low. busy rises only when the
// two-entry input queue is full, so up to two items can wait behind the one
// in conversion. Radix 0 and 1 convert as radix 2.
// Output: one digit per item position, most significant first, each shown
// for one cycle with rsp_strobe high; rsp_last_digit marks the least
// significant digit. Digits of one item come on consecutive cycles. The
// receiver cannot stall, so digits leave the moment they are popped.
// Conversion: a serial restoring divider divides the value by the radix
// repeatedly and pushes each remainder on the digit stack until the quotient
// is zero; a zero value skips the divider. The stack is then popped to the
// output. With the defaults the worst case is 31 binary digits; the divider
// sets the rate.
// Throughput: one item at a time in the converter; the queue overlaps the
// hand-off of the next item.
// Reset: synchronous; clears the queue, the converter state and the strobe.
// The digit stack is a memory with no reset; only written entries are read.
module radix_digit_converter #(
   parameter int VALUE_BITS  = 31,
   parameter int STACK_DEPTH = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [VALUE_BITS-1:0]       req_value,
   input  wire logic [rdc_pkg::RADIX_W-1:0] req_radix,
   output logic                             rsp_strobe,
   output logic [rdc_pkg::DIGIT_W-1:0]      rsp_digit,
   output logic                             rsp_last_digit
);
   import rdc_pkg::*;

   logic                  item_valid;
   logic [VALUE_BITS-1:0] item_value;
   logic [RADIX_W-1:0]    item_radix;
   logic                  item_pop;

   // front: accept, fix up radix, queue
   rdc_front #(
      .VALUE_BITS(VALUE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_value  (req_value),
      .req_radix  (req_radix),
      .item_valid (item_valid),
      .item_value (item_value),
      .item_radix (item_radix),
      .item_pop   (item_pop)
   );

   // back: divide, stack remainders, pop digits
   rdc_back #(
      .VALUE_BITS  (VALUE_BITS),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (item_valid),
      .item_value     (item_value),
      .item_radix     (item_radix),
      .item_pop       (item_pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_digit      (rsp_digit),
      .rsp_last_digit (rsp_last_digit)
   );

endmodule
`default_nettype wire

@@ src/rdc_checker.sv @@
`default_nettype none
module rdc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_strobe,
   input wire logic [5:0] rsp_digit,
   input wire logic       rsp_last_digit
);

   // no digit in the cycle after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("digit right after reset");

   // digits of one item are back to back
   a_digits_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_digit |=> rsp_strobe)
      else $error("gap inside a digit run");

   // a new item never starts right after a last digit
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_digit |=> !rsp_strobe)
      else $error("digit right after last digit");

   // queue fills only from an accept
   a_busy_from_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy without an accept");

   // digit never reaches 63 for any radix up to 63
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_digit != 6'd63)
      else $error("digit out of range");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_digit      (rsp_digit),
   .rsp_last_digit (rsp_last_digit)
);
`default_nettype wire
